### rtl/orl_pkg.sv
package orl_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W = 3;
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT  = 3'd0,
    CMD_INS_BACK   = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_REM_KEY    = 3'd3,
    CMD_REM_FRONT  = 3'd4,
    CMD_REM_BACK   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } rsp_t;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cell_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             clear_en;
    logic             scan_en;
    logic             apply_en;
  } cell_ctrl_t;

  function automatic logic is_insert(logic [CMD_W-1:0] cmd);
    return (cmd == CMD_INS_FRONT) || (cmd == CMD_INS_BACK) || (cmd == CMD_INS_SORTED);
  endfunction

  function automatic logic is_remove(logic [CMD_W-1:0] cmd);
    return (cmd == CMD_REM_KEY) || (cmd == CMD_REM_FRONT) || (cmd == CMD_REM_BACK);
  endfunction

endpackage

### rtl/orl_cell.sv
module orl_cell import orl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       is_head_i,
  input  cell_t      left_i,
  input  logic       left_incl_i,
  input  cell_t      right_i,
  output cell_t      cell_o,
  output logic       incl_o
);

  cell_t cur_q, cur_d;
  logic  incl_q, incl_d;
  logic  hit;
  logic  ins;

  assign ins = is_insert(ctrl_i.command);

  always_comb begin
    case (ctrl_i.command)
      CMD_INS_FRONT:  hit = is_head_i;
      CMD_INS_BACK:   hit = !cur_q.occ;
      CMD_INS_SORTED: hit = !cur_q.occ ||
                            (is_head_i ? ($signed(cur_q.key) > $signed(ctrl_i.key))
                                       : ($signed(cur_q.key) >= $signed(ctrl_i.key)));
      CMD_REM_KEY:    hit = cur_q.occ && (cur_q.key == ctrl_i.key);
      CMD_REM_FRONT:  hit = is_head_i && cur_q.occ;
      CMD_REM_BACK:   hit = cur_q.occ && !right_i.occ;
      default:        hit = 1'b0;
    endcase
  end

  always_comb begin
    incl_d = incl_q;
    if (ctrl_i.clear_en) begin
      incl_d = 1'b0;
    end else if (ctrl_i.scan_en) begin
      incl_d = left_incl_i | hit;
    end
  end

  always_comb begin
    cur_d = cur_q;
    if (ctrl_i.apply_en) begin
      if (ins) begin
        if (left_incl_i) begin
          cur_d = left_i;
        end else if (incl_q) begin
          cur_d = '{occ: 1'b1, key: ctrl_i.key, payload: ctrl_i.payload};
        end
      end else if (incl_q) begin
        cur_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b0;
      cur_q  <= '0;
    end else begin
      incl_q <= incl_d;
      cur_q  <= cur_d;
    end
  end

  assign cell_o = cur_q;
  assign incl_o = incl_q;

endmodule

### rtl/ordered_record_list.sv
// Bounded ordered list of DEPTH records held in a row of cells, front at cell zero. Each
// request is captured, then the position flag ripples one cell per cycle down the row in
// the scan state, and in the apply state the cells from the chosen position to the back
// shift toward or away from it at once and the response is registered. A new request
// is taken while the previous response still waits; that request then holds in its apply
// state until the response slot frees. Failed requests leave the list unchanged.
module ordered_record_list import orl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  req_t             cmd_q;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  cell_ctrl_t       ctrl;
  cell_t            cells [DEPTH];
  logic [DEPTH-1:0] incl;
  logic [DEPTH-1:0] occ_vec;

  logic accept, slot_free, full, found, ok, finish;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign full        = (cnt_q == CNT_W'(DEPTH));
  assign found       = incl[DEPTH-1];
  assign finish      = (state_q == ST_APPLY) && slot_free;

  always_comb begin
    if (is_insert(cmd_q.command)) begin
      ok = !full && found;
    end else if (is_remove(cmd_q.command)) begin
      ok = found;
    end else begin
      ok = 1'b0;
    end
  end

  assign ctrl = '{command:  cmd_q.command,
                  key:      cmd_q.entry_key,
                  payload:  cmd_q.entry_payload,
                  clear_en: accept,
                  scan_en:  (state_q == ST_SCAN),
                  apply_en: finish && ok};

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          scan_d  = '0;
        end
      end
      ST_SCAN: begin
        if (scan_q == IDX_W'(DEPTH - 1)) begin
          state_d = ST_APPLY;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_APPLY: begin
        if (slot_free) begin
          if (ok) begin
            cnt_d = is_insert(cmd_q.command) ? cnt_q + 1'b1 : cnt_q - 1'b1;
          end
          rsp_d       = '{ok: ok, entry_count: cnt_d, is_empty: (cnt_d == '0)};
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_t left_c, right_c;
    logic  left_incl;
    if (i == 0) begin : g_head
      assign left_c    = '0;
      assign left_incl = 1'b0;
    end else begin : g_body
      assign left_c    = cells[i-1];
      assign left_incl = incl[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_mid
      assign right_c = cells[i+1];
    end
    orl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .is_head_i   (i == 0),
      .left_i      (left_c),
      .left_incl_i (left_incl),
      .right_i     (right_c),
      .cell_o      (cells[i]),
      .incl_o      (incl[i])
    );
    assign occ_vec[i] = cells[i].occ;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("record count exceeds depth");

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(cnt_q)) else $error("count disagrees with occupied cells");

  a_front_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec >> 1) & ~occ_vec) == '0) else $error("occupied cells are not packed at front");

  a_failed_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish && !ok |=> $stable(cnt_q)) else $error("failed request changed the count");

  a_rsp_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.is_empty == (rsp_o.entry_count == '0)))
    else $error("empty flag disagrees with count");

endmodule

### tb/tb_top.sv
module tb_top import orl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int HOLD_OFF_CYCLES = 250;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SORTED} traffic_e;

  class list_status_checker;
    logic signed [KEY_W-1:0] keys [DEPTH];
    logic [PAY_W-1:0]        payloads [DEPTH];
    int unsigned             count;
    rsp_t                    status_due_q [$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             accepted;
    int unsigned             full_refusals;
    int unsigned             empty_refusals;
    int unsigned             absent_refusals;
    int unsigned             spare_codes;
    int unsigned             sorted_done;
    int unsigned             key_removals;

    function new();
      count = 0;
      errors = 0;
      checked = 0;
      accepted = 0;
      full_refusals = 0;
      empty_refusals = 0;
      absent_refusals = 0;
      spare_codes = 0;
      sorted_done = 0;
      key_removals = 0;
    endfunction

    function int outstanding();
      return status_due_q.size();
    endfunction

    function bit insert_at(int unsigned slot, logic signed [KEY_W-1:0] key,
                           logic [PAY_W-1:0] payload);
      if (count >= DEPTH || slot > count) begin
        full_refusals++;
        return 1'b0;
      end
      for (int unsigned i = count; i > slot; i--) begin
        keys[i] = keys[i-1];
        payloads[i] = payloads[i-1];
      end
      keys[slot] = key;
      payloads[slot] = payload;
      count++;
      return 1'b1;
    endfunction

    function bit remove_at(int unsigned slot);
      if (count == 0 || slot >= count) begin
        if (count == 0) empty_refusals++;
        else absent_refusals++;
        return 1'b0;
      end
      for (int unsigned i = slot; i + 1 < count; i++) begin
        keys[i] = keys[i+1];
        payloads[i] = payloads[i+1];
      end
      count--;
      return 1'b1;
    endfunction

    function int unsigned sorted_slot(logic signed [KEY_W-1:0] key);
      int unsigned slot;
      if (count == 0 || $signed(keys[0]) > $signed(key)) return 0;
      slot = 1;
      while (slot < count && $signed(keys[slot]) < $signed(key)) slot++;
      return slot;
    endfunction

    function int unsigned key_slot(logic signed [KEY_W-1:0] key);
      int unsigned slot;
      slot = 0;
      while (slot < count && keys[slot] != key) slot++;
      return slot;
    endfunction

    function void note_request(req_t r);
      rsp_t exp_rsp;
      bit   done;
      accepted++;
      case (r.command)
        CMD_INS_FRONT:  done = insert_at(0, r.entry_key, r.entry_payload);
        CMD_INS_BACK:   done = insert_at(count, r.entry_key, r.entry_payload);
        CMD_INS_SORTED: begin
          done = insert_at(sorted_slot(r.entry_key), r.entry_key, r.entry_payload);
          if (done) sorted_done++;
        end
        CMD_REM_KEY: begin
          done = remove_at(key_slot(r.entry_key));
          if (done) key_removals++;
        end
        CMD_REM_FRONT:  done = remove_at(0);
        CMD_REM_BACK:   done = (count != 0) ? remove_at(count - 1) : remove_at(0);
        default: begin
          done = 1'b0;
          spare_codes++;
        end
      endcase
      exp_rsp.ok = done;
      exp_rsp.entry_count = CNT_W'(count);
      exp_rsp.is_empty = (count == 0);
      status_due_q.push_back(exp_rsp);
    endfunction

    function void check_status(rsp_t got);
      rsp_t exp_rsp;
      checked++;
      if (status_due_q.size() == 0) begin
        $error("response with no request outstanding: ok %0d count %0d empty %0d",
               got.ok, got.entry_count, got.is_empty);
        errors++;
        return;
      end
      exp_rsp = status_due_q.pop_front();
      if (got.ok !== exp_rsp.ok) begin
        $error("ok: expected %0d, got %0d", exp_rsp.ok, got.ok);
        errors++;
      end
      if (got.entry_count !== exp_rsp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_empty !== exp_rsp.is_empty) begin
        $error("is_empty: expected %0d, got %0d", exp_rsp.is_empty, got.is_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  list_status_checker chk = new();
  bit holding_off = 1'b0;
  int unsigned send_burst = 0;
  int unsigned recv_burst = 0;

  always #6 clk_i = ~clk_i;

  ordered_record_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  function automatic int draw_gap(ref int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(20, 60);
    return $urandom_range(0, 11);
  endfunction

  function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
                                    logic [PAY_W-1:0] payload);
    req_t r;
    r.command = cmd;
    r.entry_key = key;
    r.entry_payload = payload;
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return KEY_W'($signed($urandom_range(0, 16)) - 8);
    if (roll < 55 && chk.count > 0) return chk.keys[$urandom_range(0, chk.count - 1)];
    if (roll < 65) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic req_t pick_request(traffic_e mode);
    req_t r;
    int   roll;
    int   ins_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:   ins_pct = 75;
      MODE_DRAIN:  ins_pct = 20;
      MODE_SORTED: ins_pct = 60;
      default:     ins_pct = 50;
    endcase
    r.entry_payload = $urandom;
    r.entry_key = pick_key();
    if (roll < 3) begin
      r.command = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end else if (roll < 3 + ins_pct) begin
      if (mode == MODE_SORTED) begin
        r.command = CMD_INS_SORTED;
      end else begin
        case ($urandom_range(0, 2))
          0: r.command = CMD_INS_FRONT;
          1: r.command = CMD_INS_BACK;
          default: r.command = CMD_INS_SORTED;
        endcase
      end
    end else begin
      case ((mode == MODE_SORTED) ? 0 : $urandom_range(0, 2))
        0: r.command = CMD_REM_KEY;
        1: r.command = CMD_REM_FRONT;
        default: r.command = CMD_REM_BACK;
      endcase
      if (r.command == CMD_REM_KEY && chk.count > 0 && $urandom_range(0, 3) != 0)
        r.entry_key = chk.keys[$urandom_range(0, chk.count - 1)];
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = holding_off ? 0 : draw_gap(send_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    chk.note_request(r);
  endtask

  task automatic wait_all_done();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
    while (chk.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin : request_side
    traffic_e mode;
    mode = MODE_FILL;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Removals and spare codes on an empty list, inserts that probe ordering, then removals.
    send_request(make_req(CMD_REM_FRONT, 32'sd0, 32'h0));
    send_request(make_req(CMD_REM_BACK, 32'sd0, 32'h0));
    send_request(make_req(CMD_REM_KEY, 32'sd0, 32'h0));
    send_request(make_req(CMD_SPARE6, 32'sd0, 32'h0));
    send_request(make_req(CMD_SPARE7, -32'sd1, 32'hffff_ffff));
    send_request(make_req(CMD_INS_SORTED, 32'sd0, 32'h0));
    send_request(make_req(CMD_INS_SORTED, 32'sh7fff_ffff, 32'hffff_ffff));
    send_request(make_req(CMD_INS_SORTED, 32'sh8000_0000, 32'h5555_5555));
    send_request(make_req(CMD_INS_SORTED, 32'sd0, 32'haaaa_aaaa));
    send_request(make_req(CMD_INS_FRONT, 32'sd5, 32'h1234_5678));
    send_request(make_req(CMD_INS_BACK, -32'sd5, 32'h8765_4321));
    send_request(make_req(CMD_INS_SORTED, 32'sd3, 32'h0000_0001));
    send_request(make_req(CMD_REM_KEY, 32'sd1234, 32'h0));
    send_request(make_req(CMD_REM_KEY, 32'sd0, 32'h0));
    send_request(make_req(CMD_REM_FRONT, 32'sd0, 32'h0));
    send_request(make_req(CMD_REM_BACK, 32'sd0, 32'h0));
    wait_all_done();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      send_request(pick_request(mode));
      if (n == 600 || n == 1400) wait_all_done();
      if (mode == MODE_FILL && chk.count == DEPTH && $urandom_range(0, 2) == 0) begin
        mode = MODE_DRAIN;
      end else if (mode == MODE_DRAIN && chk.count == 0 && $urandom_range(0, 2) == 0) begin
        mode = traffic_e'($urandom_range(0, 3));
      end else if (n % 150 == 149) begin
        mode = traffic_e'($urandom_range(0, 3));
      end
    end
    @(negedge clk_i);
    req_valid_i <= 1'b0;

    while (chk.outstanding() != 0) @(posedge clk_i);
    repeat (2 * (DEPTH + 2)) @(posedge clk_i);

    $display("%0d requests and %0d responses; %0d sorted inserts, %0d removals by key",
             chk.accepted, chk.checked, chk.sorted_done, chk.key_removals);
    $display("refused: %0d on a full list, %0d on an empty list, %0d absent keys, %0d spare codes",
             chk.full_refusals, chk.empty_refusals, chk.absent_refusals, chk.spare_codes);
    if (chk.errors == 0 && chk.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : response_side
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (chk.checked == 300 || chk.checked == 1200) begin
        holding_off = 1'b1;
        rsp_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        holding_off = 1'b0;
      end else begin
        gap = draw_gap(recv_burst);
        if (gap > 0) begin
          rsp_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rsp_ready_i <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid_o);
      chk.check_status(rsp_o);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
